### rtl/core/msic_pkg.sv
// Shared constants and types for the merge-sort inversion counter.
// Used by msic_if, msic_merge_seq and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package msic_pkg;

  localparam int DEF_MAX_ITEMS = 64;
  localparam int DATA_W        = 32;
  localparam int INV_W         = 11;

  localparam logic [INV_W-1:0] INV_MAX = '1;

  typedef struct packed {
    logic busy;
    logic done;
    logic src_buf;
  } seq_status_t;

endpackage

`default_nettype wire

### rtl/core/msic_if.sv
// Valid/ready channel interfaces for the input beats and the result beats.
// Depends on msic_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface msic_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [msic_pkg::DATA_W-1:0]  value;
  logic                                last_item;

  modport source (output valid, value, last_item, input ready);
  modport sink   (input valid, value, last_item, output ready);
endinterface

interface msic_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [msic_pkg::DATA_W-1:0]  sorted_value;
  logic        [msic_pkg::INV_W-1:0]   inversion_count;
  logic                                overflowed;
  logic                                last_result;

  modport source (output valid, sorted_value, inversion_count, overflowed, last_result,
                  input ready);
  modport sink   (input valid, sorted_value, inversion_count, overflowed, last_result,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/msic_ram.sv
// Element memory with one write port and two registered read ports.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps
`default_nettype none

module msic_ram #(
  parameter  int DEPTH = 64,
  parameter  int WIDTH = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    ra_addr,
  input  wire logic [AW-1:0]    rb_addr,
  output logic      [WIDTH-1:0] ra_data,
  output logic      [WIDTH-1:0] rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

`default_nettype wire

### rtl/core/msic_merge_seq.sv
// Bottom-up merge sequencer: one shared compare, move and count step per element.
// Depends on msic_pkg; drives the ping-pong memories through the top level.
`timescale 1ns / 1ps
`default_nettype none

module msic_merge_seq #(
  parameter  int MAX_ITEMS = msic_pkg::DEF_MAX_ITEMS,
  localparam int IDX_W     = $clog2(MAX_ITEMS),
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1)
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic        [CNT_W-1:0]            n,
  input  wire logic signed [msic_pkg::DATA_W-1:0] src_a,
  input  wire logic signed [msic_pkg::DATA_W-1:0] src_b,
  output logic             [IDX_W-1:0]            rd_a_addr,
  output logic             [IDX_W-1:0]            rd_b_addr,
  output logic                                    wr_en,
  output logic                                    wr_to_buf,
  output logic             [IDX_W-1:0]            wr_addr,
  output logic signed      [msic_pkg::DATA_W-1:0] wr_data,
  output logic             [msic_pkg::INV_W-1:0]  inv_count,
  output msic_pkg::seq_status_t                   status
);

  localparam int LW    = CNT_W + 2;
  localparam int SUM_W = ((msic_pkg::INV_W > CNT_W) ? msic_pkg::INV_W : CNT_W) + 1;

  typedef enum logic [4:0] {
    SQ_IDLE = 5'b00001,
    SQ_PASS = 5'b00010,
    SQ_RUN  = 5'b00100,
    SQ_READ = 5'b01000,
    SQ_MOVE = 5'b10000
  } sq_state_t;

  sq_state_t                   state_r, state_nxt;
  logic                        done_r, done_nxt;
  logic                        src_buf_r, src_buf_nxt;
  logic [LW-1:0]               width_r, width_nxt;
  logic [LW-1:0]               lo_r, lo_nxt;
  logic [CNT_W-1:0]            mid_r, mid_nxt;
  logic [CNT_W-1:0]            hi_r, hi_nxt;
  logic [CNT_W-1:0]            a_r, a_nxt;
  logic [CNT_W-1:0]            b_r, b_nxt;
  logic [CNT_W-1:0]            k_r, k_nxt;
  logic [msic_pkg::INV_W-1:0]  inv_r, inv_nxt;

  logic             a_live, b_live, take_a;
  logic [LW-1:0]    n_ext, mid_full, hi_full;
  logic [SUM_W-1:0] inv_sum;

  assign n_ext    = LW'(n);
  assign mid_full = lo_r + width_r;
  assign hi_full  = lo_r + (width_r << 1);
  assign a_live   = a_r < mid_r;
  assign b_live   = b_r < hi_r;
  // Ties take the left run, so equal values never count as inversions.
  assign take_a   = a_live && (!b_live || (src_a <= src_b));
  assign inv_sum  = SUM_W'(inv_r) + SUM_W'(mid_r - a_r);

  always_comb begin
    state_nxt   = state_r;
    done_nxt    = 1'b0;
    src_buf_nxt = src_buf_r;
    width_nxt   = width_r;
    lo_nxt      = lo_r;
    mid_nxt     = mid_r;
    hi_nxt      = hi_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    k_nxt       = k_r;
    inv_nxt     = inv_r;
    case (state_r)
      SQ_IDLE: begin
        if (start) begin
          width_nxt   = LW'(1);
          src_buf_nxt = 1'b0;
          inv_nxt     = '0;
          state_nxt   = SQ_PASS;
        end
      end
      SQ_PASS: begin
        if (width_r >= n_ext) begin
          done_nxt  = 1'b1;
          state_nxt = SQ_IDLE;
        end else begin
          lo_nxt    = '0;
          state_nxt = SQ_RUN;
        end
      end
      SQ_RUN: begin
        if (lo_r >= n_ext) begin
          width_nxt   = width_r << 1;
          src_buf_nxt = !src_buf_r;
          state_nxt   = SQ_PASS;
        end else begin
          mid_nxt   = (mid_full > n_ext) ? n : mid_full[CNT_W-1:0];
          hi_nxt    = (hi_full > n_ext) ? n : hi_full[CNT_W-1:0];
          a_nxt     = lo_r[CNT_W-1:0];
          b_nxt     = (mid_full > n_ext) ? n : mid_full[CNT_W-1:0];
          k_nxt     = lo_r[CNT_W-1:0];
          state_nxt = SQ_READ;
        end
      end
      SQ_READ: begin
        state_nxt = SQ_MOVE;
      end
      SQ_MOVE: begin
        if (take_a) begin
          a_nxt = a_r + CNT_W'(1);
        end else begin
          b_nxt = b_r + CNT_W'(1);
          if (a_live) begin
            inv_nxt = (inv_sum > SUM_W'(msic_pkg::INV_MAX)) ?
                      msic_pkg::INV_MAX : inv_sum[msic_pkg::INV_W-1:0];
          end
        end
        k_nxt = k_r + CNT_W'(1);
        if (k_r + CNT_W'(1) == hi_r) begin
          lo_nxt    = lo_r + (width_r << 1);
          state_nxt = SQ_RUN;
        end else begin
          state_nxt = SQ_READ;
        end
      end
      default: begin
        state_nxt = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      done_r  <= 1'b0;
      inv_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      inv_r   <= inv_nxt;
    end
    src_buf_r <= src_buf_nxt;
    width_r   <= width_nxt;
    lo_r      <= lo_nxt;
    mid_r     <= mid_nxt;
    hi_r      <= hi_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    k_r       <= k_nxt;
  end

  assign rd_a_addr      = a_r[IDX_W-1:0];
  assign rd_b_addr      = b_r[IDX_W-1:0];
  assign wr_en          = state_r == SQ_MOVE;
  assign wr_to_buf      = !src_buf_r;
  assign wr_addr        = k_r[IDX_W-1:0];
  assign wr_data        = take_a ? src_a : src_b;
  assign inv_count      = inv_r;
  assign status.busy    = state_r != SQ_IDLE;
  assign status.done    = done_r;
  assign status.src_buf = src_buf_r;

endmodule

`default_nettype wire

### rtl/core/merge_sort_inversion_count_core.sv
// Top level of the merge-sort inversion counter: load, sort sequencing, result output.
// Depends on msic_pkg, msic_if, msic_ram and msic_merge_seq.
//
//   Channel  Dir  Payload                                               Handshake
//   in_ch    in   value[31:0] signed, last_item                         valid/ready
//   out_ch   out  sorted_value[31:0] signed, inversion_count[10:0],     valid/ready
//                 overflowed, last_result
//
// Loading accepts each valid beat; in_ch.ready is high only while loading.
// The beat marked last starts the sort: ceil(log2 n) passes, each running the shared
// read, compare and move step per element, with SQ_RUN per run and SQ_PASS per pass.
// Each result beat is then read in ST_EMIT_RD and registered for output in ST_EMIT_LD.
// A stalled output holds the result stepping; the output register lets loading of the
// next set begin while the final beat waits. Reset is synchronous and needs no sweep.
`timescale 1ns / 1ps
`default_nettype none

module merge_sort_inversion_count_core #(
  parameter  int MAX_ITEMS = msic_pkg::DEF_MAX_ITEMS,
  localparam int IDX_W     = $clog2(MAX_ITEMS),
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1)
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  msic_in_if.sink    in_ch,
  msic_out_if.source out_ch
);

  typedef enum logic [3:0] {
    ST_LOAD    = 4'b0001,
    ST_SORT    = 4'b0010,
    ST_EMIT_RD = 4'b0100,
    ST_EMIT_LD = 4'b1000
  } st_t;

  st_t                                state_r, state_nxt;
  logic [CNT_W-1:0]                   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]                   ek_r, ek_nxt;
  logic                               ovf_r, ovf_nxt;
  logic                               start_r, start_nxt;
  logic                               res_buf_r, res_buf_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic signed [msic_pkg::DATA_W-1:0] out_value_r;
  logic [msic_pkg::INV_W-1:0]         out_inv_r;
  logic                               out_ovf_r;
  logic                               out_last_r;

  logic                               in_fire, room, out_load, emit_last;
  logic                               st_we, buf_we;
  logic [IDX_W-1:0]                   st_waddr, ra_addr;
  logic signed [msic_pkg::DATA_W-1:0] st_wdata;
  logic [msic_pkg::DATA_W-1:0]        st_ra, st_rb, buf_ra, buf_rb;
  logic signed [msic_pkg::DATA_W-1:0] src_a, src_b, emit_data;

  logic [IDX_W-1:0]                   seq_ra, seq_rb, seq_waddr;
  logic                               seq_we, seq_to_buf;
  logic signed [msic_pkg::DATA_W-1:0] seq_wdata;
  logic [msic_pkg::INV_W-1:0]         seq_inv;
  msic_pkg::seq_status_t              seq_st;

  assign in_ch.ready = state_r == ST_LOAD;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign room        = cnt_r < CNT_W'(MAX_ITEMS);
  assign out_load    = (state_r == ST_EMIT_LD) && (!out_valid_r || out_ch.ready);
  assign emit_last   = (ek_r + CNT_W'(1)) == cnt_r;

  assign st_we    = (in_fire && room) || (seq_we && !seq_to_buf);
  assign st_waddr = (state_r == ST_LOAD) ? cnt_r[IDX_W-1:0] : seq_waddr;
  assign st_wdata = (state_r == ST_LOAD) ? in_ch.value : seq_wdata;
  assign buf_we   = seq_we && seq_to_buf;
  assign ra_addr  = (state_r == ST_SORT) ? seq_ra : ek_r[IDX_W-1:0];

  assign src_a     = seq_st.src_buf ? buf_ra : st_ra;
  assign src_b     = seq_st.src_buf ? buf_rb : st_rb;
  assign emit_data = res_buf_r ? buf_ra : st_ra;

  msic_ram #(
    .DEPTH (MAX_ITEMS),
    .WIDTH (msic_pkg::DATA_W)
  ) u_store (
    .clk     (clk),
    .we      (st_we),
    .waddr   (st_waddr),
    .wdata   (st_wdata),
    .ra_addr (ra_addr),
    .rb_addr (seq_rb),
    .ra_data (st_ra),
    .rb_data (st_rb)
  );

  msic_ram #(
    .DEPTH (MAX_ITEMS),
    .WIDTH (msic_pkg::DATA_W)
  ) u_buf (
    .clk     (clk),
    .we      (buf_we),
    .waddr   (seq_waddr),
    .wdata   (seq_wdata),
    .ra_addr (ra_addr),
    .rb_addr (seq_rb),
    .ra_data (buf_ra),
    .rb_data (buf_rb)
  );

  msic_merge_seq #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_r),
    .n         (cnt_r),
    .src_a     (src_a),
    .src_b     (src_b),
    .rd_a_addr (seq_ra),
    .rd_b_addr (seq_rb),
    .wr_en     (seq_we),
    .wr_to_buf (seq_to_buf),
    .wr_addr   (seq_waddr),
    .wr_data   (seq_wdata),
    .inv_count (seq_inv),
    .status    (seq_st)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ek_nxt        = ek_r;
    ovf_nxt       = ovf_r;
    start_nxt     = 1'b0;
    res_buf_nxt   = res_buf_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          if (room) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.last_item) begin
            start_nxt = 1'b1;
            state_nxt = ST_SORT;
          end
        end
      end
      ST_SORT: begin
        if (seq_st.done) begin
          res_buf_nxt = seq_st.src_buf;
          ek_nxt      = '0;
          state_nxt   = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if (emit_last) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            ek_nxt    = ek_r + CNT_W'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      ek_r        <= '0;
      ovf_r       <= 1'b0;
      start_r     <= 1'b0;
      res_buf_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ek_r        <= ek_nxt;
      ovf_r       <= ovf_nxt;
      start_r     <= start_nxt;
      res_buf_r   <= res_buf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (out_load) begin
      out_value_r <= emit_data;
      out_inv_r   <= seq_inv;
      out_ovf_r   <= ovf_r;
      out_last_r  <= emit_last;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.sorted_value    = out_value_r;
  assign out_ch.inversion_count = out_inv_r;
  assign out_ch.overflowed      = out_ovf_r;
  assign out_ch.last_result     = out_last_r;

  a_load_seq_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !seq_st.busy)
    else $error("Input accepted while the merge sequencer is busy.");

  a_done_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_st.done && state_r == ST_SORT) |=> state_r == ST_EMIT_RD)
    else $error("Sort completion did not start the output phase.");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_LD || state_r == ST_EMIT_RD) |-> ek_r < cnt_r)
    else $error("Output index ran past the element count.");

  a_start_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> ($past(state_r) == ST_LOAD && state_r == ST_SORT))
    else $error("Sort started outside the end of a load.");

endmodule

`default_nettype wire
